// ===== hw/rtl/pic_pkg.sv =====
// Shared constants, access codes and types of the platform interrupt controller.
// No dependencies; every other file of the block imports this package.
package pic_pkg;

  localparam int MAX_SOURCES     = 16;
  localparam int NUM_SOURCES_DEF = 16;
  localparam int ID_W            = 4;
  localparam int PRIO_W          = 3;
  localparam int MODE_W          = 3;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = PRIO_W * MAX_SOURCES;

  // Bus access codes carried in the mode field; unlisted codes act as a tick.
  localparam logic [MODE_W-1:0] MODE_TICK       = 3'd0;
  localparam logic [MODE_W-1:0] MODE_M_CLAIM    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_S_CLAIM    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_M_COMPLETE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_S_COMPLETE = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PRIORITIES = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_M_ENABLES  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_S_ENABLES  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_M_THRESH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_S_THRESH   = 3'd4;

  typedef struct packed {
    logic [CFG_DATA_W-1:0]  priorities;
    logic [MAX_SOURCES-1:0] m_enables;
    logic [MAX_SOURCES-1:0] s_enables;
    logic [PRIO_W-1:0]      m_threshold;
    logic [PRIO_W-1:0]      s_threshold;
  } cfg_t;

  // One contender of the selection tree; priority zero means no request.
  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [ID_W-1:0]   id;
    logic              machine;
  } arb_entry_t;

  typedef struct packed {
    logic [ID_W-1:0]        read_data;
    logic [MAX_SOURCES-1:0] pending_bits;
    logic                   machine_irq;
    logic                   supervisor_irq;
    logic                   busy_res;
  } result_t;

endpackage

// ===== hw/rtl/pic_if.sv =====
// Valid/ready channel interfaces for access items and result items.
// Depends on pic_pkg for the field widths.
interface pic_in_if import pic_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [MODE_W-1:0]      mode;
  logic [ID_W-1:0]        complete_id;
  logic [MAX_SOURCES-1:0] source_lines;

  modport source (output valid, mode, complete_id, source_lines, input ready);
  modport sink   (input valid, mode, complete_id, source_lines, output ready);
endinterface

interface pic_out_if import pic_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [ID_W-1:0]        read_data;
  logic [MAX_SOURCES-1:0] pending_bits;
  logic                   machine_irq;
  logic                   supervisor_irq;
  logic                   busy_res;

  modport source (output valid, read_data, pending_bits, machine_irq, supervisor_irq,
                  busy_res, input ready);
  modport sink   (input valid, read_data, pending_bits, machine_irq, supervisor_irq,
                  busy_res, output ready);
endinterface

// ===== hw/rtl/platform_interrupt_controller.sv =====
// Platform interrupt controller, two contexts (machine and supervisor).
// An accepted access passes the input register and then the result register, which holds a stalled result.
// Throughput: one access per cycle while results are taken; the state update and the sixteen-way
// selection tree fit between the input register and the result register.
// Reset (rst_n, synchronous, active low) clears the configuration, pending,
// gateway and claim state, both interrupt lines and both pipeline valid flags.
module platform_interrupt_controller import pic_pkg::*; #(
  parameter int NUM_SOURCES = NUM_SOURCES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  pic_in_if.sink                in_ch,
  pic_out_if.source             out_ch
);

  // The input register holds one access; it moves on into the result register
  // whenever that register is empty or its current result is being taken, so
  // a single waiting result does not stop the next access from being accepted.
  logic                   s1_valid_r, s1_valid_nxt;
  logic [MODE_W-1:0]      s1_mode_r;
  logic [ID_W-1:0]        s1_cid_r;
  logic [MAX_SOURCES-1:0] s1_lines_r;
  logic                   out_valid_r, out_valid_nxt;
  result_t                out_r;
  logic                   in_xfer;
  logic                   advance;
  cfg_t                   cfg;
  result_t                result;

  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  pic_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // The controller state advances exactly once per access, when that access
  // leaves the input register, so the state and the results stay in step.
  pic_core #(
    .NUM_SOURCES (NUM_SOURCES)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (advance),
    .mode         (s1_mode_r),
    .complete_id  (s1_cid_r),
    .source_lines (s1_lines_r),
    .cfg          (cfg),
    .result       (result)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset; they are qualified by the valid flags.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_mode_r  <= in_ch.mode;
      s1_cid_r   <= in_ch.complete_id;
      s1_lines_r <= in_ch.source_lines;
    end
    if (advance) begin
      out_r <= result;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.read_data      = out_r.read_data;
  assign out_ch.pending_bits   = out_r.pending_bits;
  assign out_ch.machine_irq    = out_r.machine_irq;
  assign out_ch.supervisor_irq = out_r.supervisor_irq;
  assign out_ch.busy_res       = out_r.busy_res;

  // With the result register empty the block must always take a new access.
  a_ready_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ch.ready)
    else $error("input not ready although the result register is empty");

  // An access leaving the input register always yields a result next cycle.
  a_advance_gives_result : assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_ch.valid)
    else $error("access advanced without a result being presented");

  // Source zero has no line, so its pending bit can never be set.
  a_source_zero_idle : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !out_ch.pending_bits[0])
    else $error("pending bit of source zero set");

  // A stalled result must not be overwritten by the next access.
  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !advance)
    else $error("result register overwritten while stalled");

endmodule

// ===== hw/rtl/pic_cfg_regs.sv =====
// Configuration register file: priorities, enables and thresholds.
// Depends on pic_pkg for the register indexes and the cfg_t bundle.
module pic_cfg_regs import pic_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PRIORITIES: cfg_r.priorities  <= cfg_wdata;
        CFG_M_ENABLES:  cfg_r.m_enables   <= cfg_wdata[MAX_SOURCES-1:0];
        CFG_S_ENABLES:  cfg_r.s_enables   <= cfg_wdata[MAX_SOURCES-1:0];
        CFG_M_THRESH:   cfg_r.m_threshold <= cfg_wdata[PRIO_W-1:0];
        CFG_S_THRESH:   cfg_r.s_threshold <= cfg_wdata[PRIO_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hw/rtl/pic_arbiter.sv =====
// Four-level selection tree: highest priority wins, ties go to the lower id.
// Depends on pic_pkg for arb_entry_t; purely combinational.
module pic_arbiter import pic_pkg::*; (
  input  arb_entry_t leaf [MAX_SOURCES],
  output arb_entry_t winner
);

  // Heap layout: node 1 is the root, leaves sit at MAX_SOURCES and above.
  arb_entry_t node [1:2*MAX_SOURCES-1];

  always_comb begin
    for (int i = 0; i < MAX_SOURCES; i++) begin
      node[MAX_SOURCES + i] = leaf[i];
    end
    for (int k = MAX_SOURCES - 1; k >= 1; k--) begin
      // The left child always covers the lower ids, so it keeps a tie.
      if (node[2*k].prio >= node[2*k+1].prio) begin
        node[k] = node[2*k];
      end else begin
        node[k] = node[2*k+1];
      end
    end
  end

  assign winner = node[1];

endmodule

// ===== hw/rtl/pic_core.sv =====
// Gateway, claim/complete handling and routing state of the controller.
// Depends on pic_pkg and instantiates pic_arbiter.
module pic_core import pic_pkg::*; #(
  parameter int NUM_SOURCES = NUM_SOURCES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step_en,
  input  logic [MODE_W-1:0]      mode,
  input  logic [ID_W-1:0]        complete_id,
  input  logic [MAX_SOURCES-1:0] source_lines,
  input  cfg_t                   cfg,
  output result_t                result
);

  logic [MAX_SOURCES-1:0] pending_r, pending_nxt;
  logic [MAX_SOURCES-1:0] blocked_r, blocked_nxt;
  logic                   in_service_r, in_service_nxt;
  logic [ID_W-1:0]        current_r, current_nxt;
  logic [ID_W-1:0]        m_claim_r, m_claim_nxt;
  logic [ID_W-1:0]        s_claim_r, s_claim_nxt;
  logic [1:0]             irq_r, irq_nxt;

  logic [MAX_SOURCES-1:0] src_mask;
  logic [MAX_SOURCES-1:0] cur_onehot;
  logic [MAX_SOURCES-1:0] new_req;
  logic [ID_W-1:0]        read_data;
  logic [1:0]             irq_mid;
  logic                   service_mid;
  arb_entry_t             leaf [MAX_SOURCES];
  arb_entry_t             winner;

  for (genvar g = 0; g < MAX_SOURCES; g++) begin : g_mask
    assign src_mask[g] = (g < NUM_SOURCES);
  end

  assign cur_onehot = {{(MAX_SOURCES-1){1'b0}}, 1'b1} << current_r;

  always_comb begin
    logic                   claim;
    logic                   complete;
    logic [MAX_SOURCES-1:0] pend_c;
    logic [MAX_SOURCES-1:0] blk_c;
    logic [PRIO_W-1:0]      pr;
    logic                   valid_src;
    logic                   to_m;
    logic                   to_s;

    claim     = (mode == MODE_M_CLAIM) || (mode == MODE_S_CLAIM);
    read_data = '0;
    pend_c    = pending_r;
    blk_c     = blocked_r;
    irq_mid   = irq_r;
    service_mid = in_service_r;

    if (claim) begin
      read_data   = (mode == MODE_M_CLAIM) ? m_claim_r : s_claim_r;
      pend_c      = pend_c & ~cur_onehot;
      service_mid = 1'b1;
    end

    complete = service_mid && (complete_id == current_r) &&
               ((mode == MODE_M_COMPLETE) || (mode == MODE_S_COMPLETE));
    if (complete) begin
      blk_c       = blk_c & ~cur_onehot;
      service_mid = 1'b0;
      if (mode == MODE_M_COMPLETE) begin
        irq_mid[0] = 1'b0;
      end else begin
        irq_mid[1] = 1'b0;
      end
    end

    // Source zero has no line; an asserted source passes the gateway once, then stays blocked until completed.
    new_req     = source_lines & src_mask & ~{{(MAX_SOURCES-1){1'b0}}, 1'b1} & ~blk_c;
    pending_nxt = (pend_c | new_req) & src_mask;
    blocked_nxt = (blk_c | new_req) & src_mask;

    for (int i = 0; i < MAX_SOURCES; i++) begin
      pr        = cfg.priorities[PRIO_W*i +: PRIO_W];
      valid_src = pending_nxt[i] && !service_mid;
      to_m      = valid_src && cfg.m_enables[i] && (pr >= cfg.m_threshold);
      to_s      = valid_src && !to_m && cfg.s_enables[i] && (pr >= cfg.s_threshold);
      leaf[i].prio    = (to_m || to_s) ? pr : '0;
      leaf[i].id      = ID_W'(i);
      leaf[i].machine = to_m;
    end
  end

  pic_arbiter u_arbiter (
    .leaf   (leaf),
    .winner (winner)
  );

  always_comb begin
    irq_nxt        = irq_mid;
    in_service_nxt = service_mid;
    current_nxt    = current_r;
    m_claim_nxt    = m_claim_r;
    s_claim_nxt    = s_claim_r;
    if (winner.prio != '0) begin
      current_nxt = winner.id;
      if (winner.machine) begin
        irq_nxt[0]  = 1'b1;
        m_claim_nxt = winner.id;
      end else begin
        irq_nxt[1]  = 1'b1;
        s_claim_nxt = winner.id;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r    <= '0;
      blocked_r    <= '0;
      in_service_r <= 1'b0;
      current_r    <= '0;
      m_claim_r    <= '0;
      s_claim_r    <= '0;
      irq_r        <= '0;
    end else if (step_en) begin
      pending_r    <= pending_nxt;
      blocked_r    <= blocked_nxt;
      in_service_r <= in_service_nxt;
      current_r    <= current_nxt;
      m_claim_r    <= m_claim_nxt;
      s_claim_r    <= s_claim_nxt;
      irq_r        <= irq_nxt;
    end
  end

  assign result.read_data      = read_data;
  assign result.pending_bits   = pending_nxt;
  assign result.machine_irq    = irq_nxt[0];
  assign result.supervisor_irq = irq_nxt[1];
  assign result.busy_res       = in_service_nxt;

endmodule
